FILE: hw/rtl/rlgr_pkg.sv
// Package for the run-length Golomb-Rice encoder.
// Holds the item structs, field widths, adaptation constants and the log2 helper.
// No dependencies.
`default_nettype none

package rlgr_pkg;

  // Sample precision used by the coder (low bits of the sample field).
  localparam int SAMPLE_BITS = 16;
  localparam int SAMPLE_W    = 16;
  localparam int CFG_W       = 16;

  // Magnitude of a sample fits SAMPLE_BITS bits; the plain-mode value needs one more.
  localparam int MAG_W = SAMPLE_BITS;
  localparam int VAL_W = SAMPLE_BITS + 1;

  // Result field widths.
  localparam int LEAD_W  = 25;
  localparam int LEN_W   = 5;
  localparam int ONES_W  = 16;
  localparam int SUF_W   = 23;

  // Adaptation state widths.
  localparam int PARAM_W = 8;
  localparam int KIDX_W  = 5;
  localparam int RUN_W   = 23;

  // Adaptation constants.
  localparam logic [PARAM_W-1:0] PARAM_CAP    = 8'd191;
  localparam logic [PARAM_W-1:0] RICE_ADD_CAP = 8'd24;
  localparam logic [PARAM_W-1:0] RICE_DOWN    = 8'd2;
  localparam logic [PARAM_W-1:0] RUN_UP       = 8'd4;
  localparam logic [PARAM_W-1:0] RUN_DOWN     = 8'd5;
  localparam logic [PARAM_W-1:0] PLAIN_UP     = 8'd3;

  // Starting parameters for a small magnitude bound (k = 1, kr = 2).
  localparam logic [PARAM_W-1:0] SMALL_RUN_INIT  = 8'd8;
  localparam logic [PARAM_W-1:0] SMALL_RICE_INIT = 8'd16;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       final_sample;
  } rlgr_in_t;

  typedef struct packed {
    logic [LEAD_W-1:0] lead_bits;
    logic [LEN_W-1:0]  lead_len;
    logic              has_rice;
    logic [ONES_W-1:0] ones_count;
    logic [SUF_W-1:0]  suffix_bits;
    logic [LEN_W-1:0]  suffix_len;
    logic              block_end;
  } rlgr_out_t;

  // Floor of log2 for a nonzero value; position of the highest set bit.
  function automatic logic [KIDX_W-1:0] floor_log2(input logic [CFG_W:0] b);
    logic [KIDX_W-1:0] pos;
    pos = '0;
    for (int i = 0; i <= CFG_W; i++) begin
      if (b[i]) begin
        pos = KIDX_W'(i);
      end
    end
    return pos;
  endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/rlgr_encoder.sv
// Top level of the adaptive run-length Golomb-Rice encoder.
// Depends on rlgr_pkg for the item structs, widths and constants.
// An accepted item sits in an input register, is coded and adapted by short logic
// and lands in a result register. One item is taken every cycle while no shown
// result waits. Its result, if it has one, is written into the result register as
// the item leaves the input register and shows from there. While a shown result waits, the
// item in the input register waits too, and in_ready follows out_ready in the same
// cycle. The state update (run count, run and Rice parameters) is combinational and
// is registered as the item moves on. A zero in run mode that neither completes
// a run nor ends the block gives no result. A new magnitude bound takes effect at the
// next block start.
`default_nettype none

module rlgr_encoder (
  input  wire                logic           clk,
  input  wire                logic           rst_n,
  input  wire                logic           cfg_wr_en,
  input  wire                logic [15:0]    cfg_wr_data,
  input  wire                logic           in_valid,
  output                     logic           in_ready,
  input  wire                rlgr_pkg::rlgr_in_t  in_data,
  output                     logic           out_valid,
  input  wire                logic           out_ready,
  output                     rlgr_pkg::rlgr_out_t out_data
);

  localparam int PW = rlgr_pkg::PARAM_W;
  localparam int KW = rlgr_pkg::KIDX_W;
  localparam int RW = rlgr_pkg::RUN_W;
  localparam int MW = rlgr_pkg::MAG_W;
  localparam int VW = rlgr_pkg::VAL_W;
  localparam int LW = rlgr_pkg::LEAD_W;
  localparam int SW = rlgr_pkg::SUF_W;
  localparam int NW = rlgr_pkg::LEN_W;
  localparam int KIDX_W_P1 = rlgr_pkg::KIDX_W + 1;

  // Starting parameters derived from the magnitude bound.
  logic [PW-1:0] init_run_r, init_rice_r;
  logic [PW-1:0] init_run_nxt, init_rice_nxt;

  // Adaptation state.
  logic [PW-1:0] run_param_r, rice_param_r;
  logic [PW-1:0] run_param_nxt, rice_param_nxt;
  logic [RW-1:0] run_cnt_r, run_cnt_nxt;
  logic          blk_start_r;

  // Input register and result register.
  logic                s_valid_r;
  rlgr_pkg::rlgr_in_t  s_item_r;
  logic                out_valid_r;
  rlgr_pkg::rlgr_out_t out_item_r;
  rlgr_pkg::rlgr_out_t res_nxt;
  logic                emit;
  logic                adv;

  // Working values for the item in the input register.
  logic [PW-1:0]          rp_cur, krp_cur;
  logic [RW-1:0]          cnt_cur;
  logic [MW-1:0]          raw, mag;
  logic                   sgn;
  logic [KW-1:0]          k, kr;
  logic                   run_mode;
  logic [VW-1:0]          val, q;
  logic [SW-1:0]          suf_mask, run_mask;
  logic [RW:0]            cnt_inc;
  logic                   run_full;
  logic [PW:0]            rice_sum;
  logic [PW-1:0]          rice_add, rice_adapt, run_up_sat;
  logic [PW:0]            run_up_sum;
  logic [KIDX_W_P1-1:0]   k_p1;

  // The item advances when the result register is free or being emptied.
  assign adv      = s_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s_valid_r || adv;

  assign out_valid = out_valid_r;
  assign out_data  = out_item_r;

  // Starting parameters: a bound of 0 or 1 starts in run mode, else kr = floor(log2(M+1)).
  always_comb begin
    if (cfg_wr_data <= 16'd1) begin
      init_run_nxt  = rlgr_pkg::SMALL_RUN_INIT;
      init_rice_nxt = rlgr_pkg::SMALL_RICE_INIT;
    end else begin
      init_run_nxt  = '0;
      init_rice_nxt = {rlgr_pkg::floor_log2({1'b0, cfg_wr_data} + 17'd1), 3'b000};
    end
  end

  // Coding and adaptation for the item in the input register.
  always_comb begin
    rp_cur   = blk_start_r ? init_run_r  : run_param_r;
    krp_cur  = blk_start_r ? init_rice_r : rice_param_r;
    cnt_cur  = blk_start_r ? '0 : run_cnt_r;

    raw      = MW'(s_item_r.sample);
    sgn      = raw[MW-1];
    mag      = sgn ? (MW'(0) - raw) : raw;
    k        = rp_cur[PW-1:3];
    kr       = krp_cur[PW-1:3];
    run_mode = (k != '0);
    k_p1     = KIDX_W_P1'(k) + KIDX_W_P1'(1);

    // Value handed to the Golomb-Rice part.
    if (run_mode) begin
      val = VW'(mag) - VW'(1);
    end else begin
      val = {mag, 1'b0} - VW'(sgn);
    end
    q        = val >> kr;
    suf_mask = ~({SW{1'b1}} << kr);

    // Rice parameter adaptation on the unmasked quotient.
    rice_add = (q < VW'(rlgr_pkg::RICE_ADD_CAP)) ? PW'(q) : rlgr_pkg::RICE_ADD_CAP;
    rice_sum = {1'b0, krp_cur} + {1'b0, rice_add};
    if (q == '0) begin
      rice_adapt = (krp_cur >= rlgr_pkg::RICE_DOWN) ? (krp_cur - rlgr_pkg::RICE_DOWN) : '0;
    end else if (q == VW'(1)) begin
      rice_adapt = krp_cur;
    end else begin
      rice_adapt = (rice_sum < {1'b0, rlgr_pkg::PARAM_CAP}) ? PW'(rice_sum)
                                                             : rlgr_pkg::PARAM_CAP;
    end

    // Run counting.
    cnt_inc    = {1'b0, cnt_cur} + (RW+1)'(1);
    run_full   = (cnt_inc == ((RW+1)'(1) << k));
    run_mask   = ~({SW{1'b1}} << k);
    run_up_sum = {1'b0, rp_cur} + {1'b0, rlgr_pkg::RUN_UP};
    run_up_sat = (run_up_sum < {1'b0, rlgr_pkg::PARAM_CAP}) ? PW'(run_up_sum)
                                                             : rlgr_pkg::PARAM_CAP;

    // Defaults: no result, state unchanged.
    res_nxt        = '0;
    emit           = 1'b0;
    run_param_nxt  = rp_cur;
    rice_param_nxt = krp_cur;
    run_cnt_nxt    = cnt_cur;

    if (run_mode) begin
      if (mag == '0) begin
        // Zero in run mode: count it, a full run emits a single 0 bit.
        run_cnt_nxt = RW'(cnt_inc);
        if (run_full) begin
          res_nxt.lead_len = NW'(1);
          emit             = 1'b1;
          run_cnt_nxt      = '0;
          run_param_nxt    = run_up_sat;
        end
      end else begin
        // Nonzero ends the run: 1, partial run count, sign, then the Rice code.
        res_nxt.lead_bits   = (LW'(1) << k_p1) | (LW'(SW'(cnt_cur) & run_mask) << 1)
                            | LW'(sgn);
        res_nxt.lead_len    = NW'(k) + NW'(2);
        res_nxt.has_rice    = 1'b1;
        res_nxt.ones_count  = rlgr_pkg::ONES_W'(q);
        res_nxt.suffix_bits = SW'(val) & suf_mask;
        res_nxt.suffix_len  = NW'(kr);
        emit                = 1'b1;
        rice_param_nxt      = rice_adapt;
        run_param_nxt       = rp_cur - rlgr_pkg::RUN_DOWN;
        run_cnt_nxt         = '0;
      end
    end else begin
      // Plain mode: every sample gets a Rice code of the interleaved magnitude.
      res_nxt.has_rice    = 1'b1;
      res_nxt.ones_count  = rlgr_pkg::ONES_W'(q);
      res_nxt.suffix_bits = SW'(val) & suf_mask;
      res_nxt.suffix_len  = NW'(kr);
      emit                = 1'b1;
      rice_param_nxt      = rice_adapt;
      run_param_nxt       = (mag == '0) ? (rp_cur + rlgr_pkg::PLAIN_UP) : '0;
    end

    // Block end closes an open run with a single 0 bit and clears the count.
    if (s_item_r.final_sample) begin
      if (!emit && (run_cnt_nxt != '0)) begin
        res_nxt.lead_bits = '0;
        res_nxt.lead_len  = NW'(1);
        emit              = 1'b1;
      end
      res_nxt.block_end = 1'b1;
      run_cnt_nxt       = '0;
    end
  end

  // Configuration, control state and handshake registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      init_run_r   <= rlgr_pkg::SMALL_RUN_INIT;
      init_rice_r  <= rlgr_pkg::SMALL_RICE_INIT;
      run_param_r  <= '0;
      rice_param_r <= '0;
      run_cnt_r    <= '0;
      blk_start_r  <= 1'b1;
      s_valid_r    <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        init_run_r  <= init_run_nxt;
        init_rice_r <= init_rice_nxt;
      end
      if (in_ready) begin
        s_valid_r <= in_valid;
      end
      if (adv) begin
        run_param_r  <= run_param_nxt;
        rice_param_r <= rice_param_nxt;
        run_cnt_r    <= run_cnt_nxt;
        blk_start_r  <= s_item_r.final_sample;
        out_valid_r  <= emit;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s_item_r <= in_data;
    end
    if (adv) begin
      out_item_r <= res_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/rlgr_chk.sv
// Port-level checker for the run-length Golomb-Rice encoder, with its bind.
// Depends on rlgr_pkg for the item structs; attaches to rlgr_encoder.
`default_nettype none

module rlgr_chk (
  input wire logic                clk,
  input wire logic                rst_n,
  input wire logic                out_valid,
  input wire logic                out_ready,
  input wire rlgr_pkg::rlgr_out_t out_data
);

  // No result is shown in the cycle after reset.
  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result shown right after reset");

  // A stalled result keeps its value.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
      out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  // Every result carries at least one code bit.
  a_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
      out_valid && (out_data.lead_len == 5'd0) |-> out_data.has_rice)
    else $error("empty result");

  // Without a Rice part the Rice fields are zero.
  a_no_rice: assert property (@(posedge clk) disable iff (!rst_n)
      out_valid && !out_data.has_rice |->
        (out_data.ones_count == '0) && (out_data.suffix_bits == '0) &&
        (out_data.suffix_len == '0))
    else $error("Rice fields set without a Rice part");

  // Suffix bits stay within the suffix length.
  a_suffix: assert property (@(posedge clk) disable iff (!rst_n)
      out_valid && out_data.has_rice |->
        ((out_data.suffix_bits >> out_data.suffix_len) == '0))
    else $error("suffix bits beyond suffix length");

endmodule

bind rlgr_encoder rlgr_chk u_rlgr_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

`default_nettype wire

FILE: tb/tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for the run-length Golomb-Rice encoder (rlgr_encoder).
// Depends on rlgr_pkg for the item structs; a built-in predictor derives each expected codeword.

module tb;

  localparam int MAX_REPORTS  = 10;
  localparam int QUIET_CYCLES = 8;
  localparam int HOLD_CYCLES  = 150;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int PARAM_MAX    = 191;
  localparam int RICE_STEP    = 24;

  // Kinds of entries in the stimulus feed.
  typedef enum logic [2:0] {
    CMD_ITEM,
    CMD_CFG,
    CMD_DRAIN,
    CMD_MODE,
    CMD_HOLD
  } feed_kind_t;

  // Sample shapes used to build random blocks.
  typedef enum int {
    FLV_ZEROS,
    FLV_SMALL,
    FLV_WIDE,
    FLV_EDGE,
    FLV_MIXED
  } sample_flavor_t;

  typedef struct packed {
    feed_kind_t          kind;
    rlgr_pkg::rlgr_in_t  item;
    logic [15:0]         value;
    logic [6:0]          idle_pct;
    logic [6:0]          stall_pct;
  } feed_entry_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                cfg_wr_en = 1'b0;
  logic [15:0]         cfg_wr_data = '0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  rlgr_pkg::rlgr_in_t  in_data = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  rlgr_pkg::rlgr_out_t out_data;

  feed_entry_t         sample_feed[$];
  rlgr_pkg::rlgr_out_t expected_codes[$];

  int   err_count = 0;
  int   result_count = 0;
  int   cycle_count = 0;
  int   quiet_left = 0;
  int   send_idle_pct = 0;
  int   stall_pct = 0;
  int   hold_reqs = 0;
  int   hold_seen = 0;
  int   hold_left = 0;
  bit   item_taken = 1'b0;

  // Predictor copy of the register and the adaptive state.
  logic [15:0] bound_reg;
  logic [7:0]  run_scaled;
  logic [7:0]  rice_scaled;
  logic [23:0] zero_run;
  bit          blk_start;

  rlgr_encoder u_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // Golomb-Rice part of a codeword, with the Rice parameter adaptation.
  function automatic void rice_part(input int unsigned value,
                                    inout rlgr_pkg::rlgr_out_t res);
    int unsigned kr;
    int unsigned q;
    int unsigned sum;
    kr = rice_scaled >> 3;
    q = value >> kr;
    res.has_rice = 1'b1;
    res.ones_count = rlgr_pkg::ONES_W'(q);
    res.suffix_bits = rlgr_pkg::SUF_W'(value & ((32'd1 << kr) - 1));
    res.suffix_len = rlgr_pkg::LEN_W'(kr);
    if (q == 0) begin
      rice_scaled = (rice_scaled >= 8'd2) ? rice_scaled - 8'd2 : 8'd0;
    end else if (q != 1) begin
      sum = rice_scaled + ((q < RICE_STEP) ? q : RICE_STEP);
      rice_scaled = (sum < PARAM_MAX) ? 8'(sum) : 8'(PARAM_MAX);
    end
  endfunction

  // Codes one sample and updates the state; returns 1 when a codeword comes out.
  function automatic bit encode_sample(input rlgr_pkg::rlgr_in_t it,
                                       output rlgr_pkg::rlgr_out_t res);
    logic [15:0]  raw;
    logic         sgn;
    int unsigned  mag;
    int unsigned  k;
    int unsigned  b;
    int unsigned  kr;
    int unsigned  runv;
    int unsigned  sum;
    logic [63:0]  lead;
    bit           emit;
    raw = it.sample;
    sgn = raw[15];
    mag = sgn ? (32'h10000 - raw) : raw;
    res = '0;
    emit = 1'b0;

    // A new block reloads both parameters from the magnitude bound.
    if (blk_start) begin
      b = bound_reg + 1;
      if (b <= 2) begin
        run_scaled = 8'd8;
        rice_scaled = 8'd16;
      end else begin
        kr = 0;
        while (b > 1) begin
          b = b >> 1;
          kr++;
        end
        run_scaled = 8'd0;
        rice_scaled = 8'(kr << 3);
      end
      zero_run = '0;
      blk_start = 1'b0;
    end

    k = run_scaled >> 3;
    if (k != 0) begin
      if (mag == 0) begin
        // Zeros are counted; only a full run of 2^k gives a single 0 bit.
        zero_run = zero_run + 1;
        if (zero_run == (32'd1 << k)) begin
          res.lead_len = rlgr_pkg::LEN_W'(1);
          emit = 1'b1;
          zero_run = '0;
          sum = run_scaled + 4;
          run_scaled = (sum < PARAM_MAX) ? 8'(sum) : 8'(PARAM_MAX);
        end
      end else begin
        runv = zero_run & ((32'd1 << k) - 1);
        lead = (64'd1 << (k + 1)) | (64'(runv) << 1) | 64'(sgn);
        res.lead_bits = lead[rlgr_pkg::LEAD_W-1:0];
        res.lead_len = rlgr_pkg::LEN_W'(k + 2);
        emit = 1'b1;
        rice_part(mag - 1, res);
        run_scaled = run_scaled - 8'd5;
        zero_run = '0;
      end
    end else begin
      rice_part(mag * 2 - sgn, res);
      emit = 1'b1;
      run_scaled = (mag == 0) ? run_scaled + 8'd3 : 8'd0;
    end

    // The last sample closes an open run and ends the block.
    if (it.final_sample) begin
      if (!emit && zero_run != 0) begin
        res.lead_bits = '0;
        res.lead_len = rlgr_pkg::LEN_W'(1);
        emit = 1'b1;
      end
      res.block_end = 1'b1;
      zero_run = '0;
      blk_start = 1'b1;
    end
    return emit;
  endfunction

  function automatic int pick_sample(input sample_flavor_t flv);
    int r;
    if (flv == FLV_MIXED) begin
      flv = sample_flavor_t'($urandom_range(3));
    end
    case (flv)
      FLV_ZEROS: begin
        r = 0;
        if ($urandom_range(99) >= 85) begin
          r = $urandom_range(3, 1);
          if ($urandom_range(1) == 1) begin
            r = -r;
          end
        end
      end
      FLV_SMALL: begin
        r = int'($urandom_range(31)) - 16;
      end
      FLV_WIDE: begin
        r = int'($urandom());
      end
      default: begin
        case ($urandom_range(6))
          0: r = 0;
          1: r = 1;
          2: r = -1;
          3: r = 32767;
          4: r = -32768;
          5: r = 16384;
          default: r = -16384;
        endcase
      end
    endcase
    return r;
  endfunction

  task automatic push_item(input int s, input bit last);
    feed_entry_t e;
    e = '0;
    e.kind = CMD_ITEM;
    e.item.sample = 16'(s);
    e.item.final_sample = last;
    sample_feed.push_back(e);
  endtask

  task automatic push_ctl(input feed_kind_t kind, input logic [15:0] value,
                          input int idle, input int stall);
    feed_entry_t e;
    e = '0;
    e.kind = kind;
    e.value = value;
    e.idle_pct = 7'(idle);
    e.stall_pct = 7'(stall);
    sample_feed.push_back(e);
  endtask

  // Driver: offers items, writes the register and pauses as the feed asks.
  always @(negedge clk) begin
    feed_entry_t         e;
    logic                nv;
    rlgr_pkg::rlgr_in_t  nd;
    logic                nwe;
    logic [15:0]         nwd;
    nv = in_valid && !item_taken;
    nd = in_data;
    nwe = 1'b0;
    nwd = cfg_wr_data;
    if (rst_n && !nv) begin
      if (quiet_left != 0) begin
        quiet_left--;
      end else if (sample_feed.size() != 0) begin
        e = sample_feed[0];
        case (e.kind)
          CMD_ITEM: begin
            if ($urandom_range(99) >= send_idle_pct) begin
              nv = 1'b1;
              nd = e.item;
              sample_feed.delete(0);
            end
          end
          CMD_CFG: begin
            nwe = 1'b1;
            nwd = e.value;
            sample_feed.delete(0);
          end
          CMD_DRAIN: begin
            // Wait for every codeword, then pause so that items without one drain too.
            if (expected_codes.size() == 0) begin
              quiet_left = QUIET_CYCLES;
              sample_feed.delete(0);
            end
          end
          CMD_MODE: begin
            send_idle_pct <= e.idle_pct;
            stall_pct <= e.stall_pct;
            sample_feed.delete(0);
          end
          default: begin
            hold_reqs <= hold_reqs + 1;
            sample_feed.delete(0);
          end
        endcase
      end
    end
    in_valid <= nv;
    in_data <= nd;
    cfg_wr_en <= nwe;
    cfg_wr_data <= nwd;
  end

  // Receiver: random stalls, plus a long hold-off when the driver requests one.
  always @(negedge clk) begin
    if (hold_seen != hold_reqs) begin
      hold_seen <= hold_reqs;
      hold_left <= HOLD_CYCLES;
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Monitor: tracks register writes, predicts accepted items and checks results.
  always @(posedge clk) begin
    rlgr_pkg::rlgr_out_t want;
    rlgr_pkg::rlgr_out_t got;
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles with %0d codewords outstanding",
               cycle_count, expected_codes.size());
      $display("Verification failed");
      $finish;
    end
    if (!rst_n) begin
      bound_reg = '0;
      run_scaled = '0;
      rice_scaled = '0;
      zero_run = '0;
      blk_start = 1'b1;
      item_taken = 1'b0;
    end else begin
      if (cfg_wr_en) begin
        bound_reg = cfg_wr_data;
      end
      if (out_valid && out_ready) begin
        got = out_data;
        result_count++;
        if (expected_codes.size() == 0) begin
          err_count++;
          if (err_count <= MAX_REPORTS) begin
            $display("result %0d arrived with no codeword pending: %h", result_count, got);
          end
        end else begin
          want = expected_codes.pop_front();
          if (got.lead_bits !== want.lead_bits || got.lead_len !== want.lead_len ||
              got.has_rice !== want.has_rice || got.ones_count !== want.ones_count ||
              got.suffix_bits !== want.suffix_bits || got.suffix_len !== want.suffix_len ||
              got.block_end !== want.block_end) begin
            err_count++;
            if (err_count <= MAX_REPORTS) begin
              $display("result %0d: expected lead %h/%0d rice %0b ones %0d suf %h/%0d end %0b",
                       result_count, want.lead_bits, want.lead_len, want.has_rice,
                       want.ones_count, want.suffix_bits, want.suffix_len, want.block_end);
              $display("  actual lead %h/%0d rice %0b ones %0d suffix %h/%0d end %0b",
                       got.lead_bits, got.lead_len, got.has_rice, got.ones_count,
                       got.suffix_bits, got.suffix_len, got.block_end);
            end
          end
        end
      end
      item_taken = in_valid && in_ready;
      if (item_taken) begin
        if (encode_sample(in_data, want)) begin
          expected_codes.push_back(want);
        end
      end
    end
  end

  // Stimulus plan, reset and end of run.
  initial begin
    logic [15:0]    bounds[8];
    int             idle_mode[4];
    int             stall_mode[4];
    int             quota;
    int             len;
    int             pick;
    bit             closed;
    sample_flavor_t flv;

    idle_mode = '{0, 62, 0, 27};
    stall_mode = '{0, 0, 62, 27};
    bounds = '{16'd0, 16'hFFFF, 16'd1, 16'($urandom()), 16'd2,
               16'($urandom()), 16'd255, 16'($urandom_range(1023))};

    // Directed items under the reset bound of zero: run mode with k = 1 and kr = 2.
    push_ctl(CMD_MODE, '0, 0, 0);
    push_item(0, 1'b0);
    push_item(0, 1'b0);
    push_item(5, 1'b0);
    push_item(-32768, 1'b0);
    push_item(32767, 1'b0);
    push_item(-1, 1'b0);
    push_item(1, 1'b0);
    push_item(0, 1'b0);
    push_item(0, 1'b0);
    push_item(0, 1'b0);
    // Final zero with a run still open, then a block of one item.
    push_item(0, 1'b1);
    push_item(-3, 1'b1);
    // Largest bound: plain mode with kr = 16.
    push_ctl(CMD_DRAIN, '0, 0, 0);
    push_ctl(CMD_CFG, 16'hFFFF, 0, 0);
    push_item(0, 1'b0);
    push_item(-32768, 1'b0);
    push_item(32767, 1'b0);
    push_item(0, 1'b1);
    // Bound of two: plain mode with kr = 1, then a partial run broken by a negative item.
    push_ctl(CMD_DRAIN, '0, 0, 0);
    push_ctl(CMD_CFG, 16'd2, 0, 0);
    push_item(-2, 1'b0);
    push_item(2, 1'b0);
    push_item(0, 1'b0);
    push_item(0, 1'b0);
    push_item(0, 1'b0);
    push_item(0, 1'b0);
    push_item(-7, 1'b0);
    push_item(0, 1'b1);

    // Random phases, each with its own bound and idling pattern. A phase may leave
    // its last block open, so the next register write lands in mid-block.
    for (int p = 0; p < 8; p++) begin
      push_ctl(CMD_DRAIN, '0, 0, 0);
      push_ctl(CMD_CFG, bounds[p], 0, 0);
      push_ctl(CMD_MODE, '0, idle_mode[p % 4], stall_mode[p % 4]);
      if (p % 4 == 0) begin
        push_ctl(CMD_HOLD, '0, 0, 0);
      end
      quota = 100;
      while (quota > 0) begin
        pick = $urandom_range(99);
        if (pick < 45) begin
          flv = FLV_ZEROS;
        end else if (pick < 70) begin
          flv = FLV_SMALL;
        end else if (pick < 85) begin
          flv = FLV_WIDE;
        end else if (pick < 93) begin
          flv = FLV_EDGE;
        end else begin
          flv = FLV_MIXED;
        end
        // Occasional long zero-heavy blocks let the run parameter climb.
        if ($urandom_range(9) == 0) begin
          len = $urandom_range(300, 100);
          flv = FLV_ZEROS;
        end else begin
          len = $urandom_range(40, 1);
        end
        closed = ($urandom_range(9) != 0);
        for (int i = 0; i < len; i++) begin
          push_item(pick_sample(flv), closed && (i == len - 1));
        end
        quota -= len;
      end
    end
    push_item(0, 1'b1);

    repeat (11) @(negedge clk);
    rst_n <= 1'b1;

    while (sample_feed.size() != 0 || in_valid) @(posedge clk);
    while (expected_codes.size() != 0) @(posedge clk);
    repeat (QUIET_CYCLES) @(posedge clk);

    if (err_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
